### src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  // wide enough for child indices and the element count
  localparam int unsigned IDX_W    = ADDR_W + 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

endpackage

### src/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq interfaces
// Operation and result channels of the heap queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmhq_in_if import bmhq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bmhq_out_if import bmhq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         element_count_out;

  modport source (output valid, output popped_value, output status,
                  output element_count_out, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input element_count_out, output ready);
endinterface

### src/binary_max_heap_queue_top.sv
// Append, rejected operations and a build of fewer than two elements go straight to
// DONE; insert reads one parent per level climbed and stops at the root or at a parent
// not smaller than the value; pop reads the root, then the last element, and sifts
// down unless it took the last one; build sifts down each node from count/2 to 0.
// One operation in flight; the next can be taken in the cycle its result is valid and
// an untaken result stalls it before output. Reset clears the count and control only.
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Binary max-heap of signed words held in a one-read one-write memory, with
// a sequencer for sift-up, sift-down and bottom-up build.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top import bmhq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_in_if.sink    in_i,
  bmhq_out_if.source out_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POP_A  = 4'd1;
  localparam logic [3:0] S_POP_B  = 4'd2;
  localparam logic [3:0] S_POP_C  = 4'd3;
  localparam logic [3:0] S_UP_RD  = 4'd4;
  localparam logic [3:0] S_UP_CMP = 4'd5;
  localparam logic [3:0] S_DN_RDL = 4'd6;
  localparam logic [3:0] S_DN_RDR = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;
  localparam logic [3:0] S_BLD_RD = 4'd9;
  localparam logic [3:0] S_BLD_LD = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic [ADDR_W-1:0]        k_q, k_d;
  logic                     bld_q, bld_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;
  logic signed [DATA_W-1:0] lval_q, lval_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  logic [STAT_W-1:0]        status_q, status_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_popped_q, out_popped_d;
  logic [STAT_W-1:0]        out_status_q, out_status_d;
  logic [CNT_W-1:0]         out_cnt_q, out_cnt_d;

  // heap memory
  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0]        raddr;
  logic [ADDR_W-1:0]        waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     we;

  logic [IDX_W-1:0]         left_idx, right_idx, cnt_ext;
  logic [ADDR_W-1:0]        parent_idx;
  logic                     left_ok, right_ok;
  logic                     sel_left, sel_right;
  logic signed [DATA_W-1:0] best_val;
  logic                     in_xfer;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign cnt_ext    = IDX_W'(cnt_q);
  assign left_idx   = IDX_W'({pos_q, 1'b1});
  assign right_idx  = left_idx + IDX_W'(1);
  assign left_ok    = left_idx < cnt_ext;
  assign right_ok   = right_idx < cnt_ext;
  assign parent_idx = (pos_q - ADDR_W'(1)) >> 1;

  // larger child wins only when strictly greater, ties keep the parent
  assign sel_left  = cur_q < lval_q;
  assign best_val  = sel_left ? lval_q : cur_q;
  assign sel_right = right_ok && (best_val < rdata_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    k_d          = k_q;
    bld_d        = bld_q;
    cur_d        = cur_q;
    lval_d       = lval_q;
    popped_d     = popped_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_popped_d = out_popped_q;
    out_status_d = out_status_q;
    out_cnt_d    = out_cnt_q;
    raddr        = '0;
    waddr        = pos_q;
    wdata        = cur_q;
    we           = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          popped_d = '0;
          status_d = ST_OK;
          bld_d    = 1'b0;
          state_d  = S_DONE;
          unique case (in_i.kind)
            KIND_INSERT: begin
              if (cnt_q == CNT_FULL) begin
                status_d = ST_FULL;
              end else begin
                cur_d   = in_i.value;
                pos_d   = cnt_q[ADDR_W-1:0];
                cnt_d   = cnt_q + CNT_W'(1);
                state_d = S_UP_RD;
              end
            end
            KIND_APPEND: begin
              if (cnt_q == CNT_FULL) begin
                status_d = ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[ADDR_W-1:0];
                wdata = in_i.value;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            KIND_POP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_POP_A;
              end
            end
            KIND_BUILD: begin
              if (cnt_q > CNT_W'(1)) begin
                k_d     = ADDR_W'(cnt_q >> 1);
                bld_d   = 1'b1;
                state_d = S_BLD_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_POP_A: begin
        raddr   = '0;
        state_d = S_POP_B;
      end
      S_POP_B: begin
        popped_d = rdata_q;
        raddr    = ADDR_W'(cnt_q - CNT_W'(1));
        cnt_d    = cnt_q - CNT_W'(1);
        state_d  = S_POP_C;
      end
      S_POP_C: begin
        cur_d = rdata_q;
        pos_d = '0;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DN_RDL;
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          raddr   = parent_idx;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (rdata_q < cur_q) begin
          wdata   = rdata_q;
          pos_d   = parent_idx;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN_RDL: begin
        if (!left_ok) begin
          // node is a leaf: drop the held value into the hole
          we = 1'b1;
          if (bld_q && (k_q != '0)) begin
            k_d     = k_q - ADDR_W'(1);
            state_d = S_BLD_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          raddr   = left_idx[ADDR_W-1:0];
          state_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lval_d  = rdata_q;
        raddr   = right_idx[ADDR_W-1:0];
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (sel_right) begin
          wdata   = rdata_q;
          pos_d   = right_idx[ADDR_W-1:0];
          state_d = S_DN_RDL;
        end else if (sel_left) begin
          wdata   = lval_q;
          pos_d   = left_idx[ADDR_W-1:0];
          state_d = S_DN_RDL;
        end else if (bld_q && (k_q != '0)) begin
          k_d     = k_q - ADDR_W'(1);
          state_d = S_BLD_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_BLD_RD: begin
        raddr   = k_q;
        state_d = S_BLD_LD;
      end
      S_BLD_LD: begin
        cur_d   = rdata_q;
        pos_d   = k_q;
        state_d = S_DN_RDL;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_popped_d = popped_q;
          out_status_d = status_q;
          out_cnt_d    = cnt_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      bld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bld_q       <= bld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    k_q          <= k_d;
    cur_q        <= cur_d;
    lval_q       <= lval_d;
    popped_q     <= popped_d;
    status_q     <= status_d;
    out_popped_q <= out_popped_d;
    out_status_q <= out_status_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.popped_value      = out_popped_q;
  assign out_o.status            = out_status_q;
  assign out_o.element_count_out = out_cnt_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("element count above capacity");

  a_pos_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RDL ||
     state_q == S_DN_RDR || state_q == S_DN_CMP) |-> (CNT_W'(pos_q) < cnt_q))
    else $error("sift position outside stored elements");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |-> (out_o.element_count_out == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_FULL) |-> (out_o.element_count_out == CNT_FULL))
    else $error("full status with count below capacity");

  a_popped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> (out_o.popped_value == '0))
    else $error("rejected operation returned a value");

endmodule
